>>> sv/nrm_pkg.sv
// ----------------------------------------------------------------------------
// nrm_pkg: shared types and constants for the NV21 region mosaic
// Register indexes, payload structs, pipeline records and the block-size
// helper shared by the mosaic core and its sub-units.
// ----------------------------------------------------------------------------
package nrm_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int SLOT_W     = $clog2(MAX_WIDTH);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_RIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_BOTTOM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MOSAIC_LEVEL = 3'd6;

	// Block size arithmetic: level * extent fits 20 bits, divide by 100
	// through a reciprocal that is exact for every product below 2^20.
	localparam int PCT_W       = 20;
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 27;
	localparam int PROD_W      = PCT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1342178;

	// Block size and phase remainder widths
	localparam int BLK_W      = 14;
	localparam int DVD_W      = 13;
	localparam int MOD_STAGES = 4;
	localparam int MOD_STEPS  = 4;
	localparam int SUB_W      = BLK_W + MOD_STAGES * MOD_STEPS;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_end;
	} out_t;

	// Per-byte record carried down the front pipeline
	typedef struct packed {
		logic [7:0]        px;
		logic [SLOT_W-1:0] slot;
		logic              is_luma;
		logic              in_rect;
		logic              frame_end;
		logic              origin;
	} item_t;

	// Request into the line store / writeback stage
	typedef struct packed {
		logic [7:0]        px;
		logic [SLOT_W-1:0] slot;
		logic              is_luma;
		logic              in_rect;
		logic              frame_end;
		logic              rph_zero;
		logic              cph_zero;
		logic              cph_one;
		logic              cph_odd;
	} wb_req_t;

	// Block size: floor(p / 100), rounded down to even, at least 2
	function automatic logic [BLK_W-1:0] blk_size(input logic [PCT_W-1:0] p);
		logic [PROD_W-1:0] prod;
		logic [BLK_W-1:0]  q;
		prod = PROD_W'(p) * PROD_W'(RECIP);
		q    = prod[RECIP_SHIFT +: BLK_W];
		q[0] = 1'b0;
		if (q < BLK_W'(2)) begin
			q = BLK_W'(2);
		end
		return q;
	endfunction

endpackage

>>> sv/nrm_modpipe.sv
// ----------------------------------------------------------------------------
// nrm_modpipe: pipelined remainder unit
// Restoring remainder of a block offset by the block size, a few
// compare-subtract steps per stage, one new operand pair every cycle while en is high.
// ----------------------------------------------------------------------------
module nrm_modpipe
	import nrm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [DVD_W-1:0] dividend,
	input  logic [BLK_W-1:0] divisor,
	output logic [DVD_W-1:0] remainder
);

	logic [DVD_W-1:0] rem_q [MOD_STAGES];
	logic [BLK_W-1:0] div_q [MOD_STAGES];
	logic [DVD_W-1:0] rem_in [MOD_STAGES];
	logic [BLK_W-1:0] div_in [MOD_STAGES];

	// Subtract the shifted divisor wherever it fits, highest shift first
	function automatic logic [DVD_W-1:0] mod_steps(input logic [DVD_W-1:0] r_in,
			input logic [BLK_W-1:0] d, input int stage);
		logic [DVD_W-1:0] r;
		logic [SUB_W-1:0] sub;
		int               sh;
		r = r_in;
		for (int j = 0; j < MOD_STEPS; j++) begin
			sh  = MOD_STEPS * (MOD_STAGES - 1 - stage) + (MOD_STEPS - 1 - j);
			sub = SUB_W'(d) << sh;
			if (sub <= SUB_W'(r)) begin
				r = r - sub[DVD_W-1:0];
			end
		end
		return r;
	endfunction

	for (genvar g = 0; g < MOD_STAGES; g++) begin : g_stage
		// Chain stage inputs
		if (g == 0) begin : g_first
			assign rem_in[g] = dividend;
			assign div_in[g] = divisor;
		end else begin : g_next
			assign rem_in[g] = rem_q[g-1];
			assign div_in[g] = div_q[g-1];
		end

		// Advance one stage of steps
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_q[g] <= '0;
				div_q[g] <= BLK_W'(2);
			end else if (en) begin
				rem_q[g] <= mod_steps(rem_in[g], div_in[g], g);
				div_q[g] <= div_in[g];
			end
		end
	end

	assign remainder = rem_q[MOD_STAGES-1];

	// The finished remainder is always below its divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		SUB_W'(rem_q[MOD_STAGES-1]) < SUB_W'(div_q[MOD_STAGES-1]))
		else $error("remainder not reduced below block size");

endmodule

>>> sv/nrm_line_wb.sv
// ----------------------------------------------------------------------------
// nrm_line_wb: line store and writeback stage
// Reads the previous row's output byte, picks the mosaic value, updates the
// held luma and chroma pair, and writes the result back into the line store.
// ----------------------------------------------------------------------------
module nrm_line_wb
	import nrm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  logic    req_valid,
	input  wb_req_t req,
	output logic    res_valid,
	output out_t    res
);

	logic [7:0] line_mem [MAX_WIDTH];

	wb_req_t    req_s8;
	logic       v_s8;
	logic [7:0] rd_q;
	logic       fwd_hit_q;
	logic [7:0] fwd_data_q;
	logic [7:0] held_luma_q;
	logic [15:0] held_chroma_q;

	logic [7:0]  line_byte;
	logic [7:0]  res_byte;
	logic [7:0]  luma_nx;
	logic [15:0] chroma_nx;

	// Pick the mosaic value for the byte in the writeback stage
	always_comb begin
		line_byte = fwd_hit_q ? fwd_data_q : rd_q;
		res_byte  = req_s8.px;
		luma_nx   = held_luma_q;
		chroma_nx = held_chroma_q;
		if (req_s8.in_rect) begin
			priority if (!req_s8.rph_zero) begin
				res_byte = line_byte;
			end else if (req_s8.is_luma) begin
				if (req_s8.cph_zero) begin
					luma_nx = req_s8.px;
				end else begin
					res_byte = held_luma_q;
				end
			end else if (req_s8.cph_zero) begin
				chroma_nx[7:0] = req_s8.px;
			end else if (req_s8.cph_one) begin
				chroma_nx[15:8] = req_s8.px;
			end else begin
				res_byte = req_s8.cph_odd ? held_chroma_q[15:8] : held_chroma_q[7:0];
			end
		end
	end

	// Read the line store for the incoming request, write back the result
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s8     <= req;
			rd_q       <= line_mem[req.slot];
			fwd_data_q <= res_byte;
			if (v_s8) begin
				line_mem[req_s8.slot] <= res_byte;
			end
		end
	end

	// Advance control and held samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8          <= 1'b0;
			fwd_hit_q     <= 1'b0;
			held_luma_q   <= '0;
			held_chroma_q <= '0;
		end else if (adv) begin
			v_s8      <= req_valid;
			fwd_hit_q <= v_s8 && (req_s8.slot == req.slot);
			if (v_s8) begin
				held_luma_q   <= luma_nx;
				held_chroma_q <= chroma_nx;
			end
		end
	end

	assign res_valid     = v_s8;
	assign res.pixel_out = res_byte;
	assign res.frame_end = req_s8.frame_end;

	// Held samples change only when a request retires
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && v_s8) |=> $stable(held_luma_q) && $stable(held_chroma_q))
		else $error("held sample changed without a retiring request");

endmodule

>>> sv/nv21_region_mosaic_core.sv
// ----------------------------------------------------------------------------
// nv21_region_mosaic_core: NV21 rectangle pixelation, one byte per clock
//
//   port group   dir   handshake            payload
//   src_*        in    src_valid/src_ready  in_t  {pixel_in, frame_start}
//   dst_*        out   dst_valid/dst_ready  out_t {pixel_out, frame_end}
//   cfg_*        in    cfg_we               cfg_index, cfg_data
//
// One byte enters per clock while dst does not stall. The rate is set by the
// line store: one read and one write per cycle, with the block phases coming
// out of a 4-stage remainder pipeline in front. Reset clears position, block
// size and held samples; the line store has no clearing pass. A stall at dst
// freezes the whole pipeline; src_ready follows.
// ----------------------------------------------------------------------------
module nv21_region_mosaic_core
	import nrm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  in_t                   src_data,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output out_t                  dst_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [11:0] rect_left_q;
	logic [11:0] rect_top_q;
	logic [12:0] rect_right_q;
	logic [12:0] rect_bottom_q;
	logic [6:0]  mosaic_level_q;

	// Stream position and latched block size
	logic [SLOT_W-1:0] col_q;
	logic [12:0]       row_q;
	logic [BLK_W-1:0]  blk_w_q;
	logic [BLK_W-1:0]  blk_h_q;

	logic adv;

	// Input stage signals
	logic [SLOT_W-1:0] col;
	logic [12:0]       row;
	logic [12:0]       w;
	logic [12:0]       h;
	logic [13:0]       total;
	logic [13:0]       row_off;
	logic [13:0]       ly;
	logic [11:0]       left;
	logic [11:0]       top;
	logic [12:0]       ext_w;
	logic [12:0]       ext_h;
	logic [12:0]       col1;
	logic [13:0]       row1;
	item_t             item_in;

	// Pipeline registers
	logic             v_s1, v_s2, v_s3;
	item_t            item_s1, item_s2, item_s3;
	logic [DVD_W-1:0] dcol_s1, dcol_s2, dcol_s3;
	logic [DVD_W-1:0] drow_s1, drow_s2, drow_s3;
	logic [PCT_W-1:0] pw_s1, ph_s1;
	logic [BLK_W-1:0] szw_s2, szh_s2;
	logic [BLK_W-1:0] bw_s3, bh_s3;
	logic             v_mod_s [MOD_STAGES];
	item_t            item_mod_s [MOD_STAGES];

	logic [DVD_W-1:0] rem_col;
	logic [DVD_W-1:0] rem_row;
	wb_req_t          wb_req;
	logic             res_valid;
	out_t             res;
	logic             dst_valid_q;
	out_t             dst_data_q;

	assign adv       = !dst_valid_q || dst_ready;
	assign src_ready = adv;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 13'd1920;
			frame_height_q <= 13'd1080;
			rect_left_q    <= '0;
			rect_top_q     <= '0;
			rect_right_q   <= '0;
			rect_bottom_q  <= '0;
			mosaic_level_q <= 7'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				CFG_RECT_LEFT:    rect_left_q    <= cfg_data[11:0];
				CFG_RECT_TOP:     rect_top_q     <= cfg_data[11:0];
				CFG_RECT_RIGHT:   rect_right_q   <= cfg_data;
				CFG_RECT_BOTTOM:  rect_bottom_q  <= cfg_data;
				CFG_MOSAIC_LEVEL: mosaic_level_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Locate the incoming byte and classify it against the rectangle
	always_comb begin
		col = src_data.frame_start ? '0 : col_q;
		row = src_data.frame_start ? '0 : row_q;

		if (frame_width_q < 13'd2) begin
			w = 13'd2;
		end else if (frame_width_q > 13'(MAX_WIDTH)) begin
			w = 13'(MAX_WIDTH);
		end else begin
			w = frame_width_q;
		end
		if (frame_height_q < 13'd2) begin
			h = 13'd2;
		end else if (frame_height_q > 13'(MAX_HEIGHT)) begin
			h = 13'(MAX_HEIGHT);
		end else begin
			h = frame_height_q;
		end
		total = 14'(h) + 14'(h >> 1);

		left    = {rect_left_q[11:1], 1'b0};
		top     = {rect_top_q[11:1], 1'b0};
		row_off = 14'(row) - 14'(h);
		ly      = (row < h) ? 14'(row) : {row_off[12:0], 1'b0};

		ext_w = (rect_right_q > 13'(left)) ? rect_right_q - 13'(left) : '0;
		ext_h = (rect_bottom_q > 13'(top)) ? rect_bottom_q - 13'(top) : '0;

		item_in.px        = src_data.pixel_in;
		item_in.slot      = col;
		item_in.is_luma   = row < h;
		item_in.in_rect   = (ly >= 14'(top)) && (ly < 14'(rect_bottom_q))
			&& (col >= left) && (13'(col) < rect_right_q);
		item_in.frame_end = (14'(row) == total - 14'd1) && (13'(col) == w - 13'd1);
		item_in.origin    = (col == '0) && (row == '0);

		col1 = 13'(col) + 13'd1;
		row1 = 14'(row) + 14'd1;
	end

	// Advance the stream position on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (src_valid && adv) begin
			if (col1 >= w) begin
				col_q <= '0;
				row_q <= (row1 >= total) ? '0 : row1[12:0];
			end else begin
				col_q <= col1[SLOT_W-1:0];
				row_q <= row;
			end
		end
	end

	// Front pipeline payload: offsets, size products, sizes
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_in;
			dcol_s1 <= DVD_W'(13'(col) - 13'(left));
			drow_s1 <= DVD_W'(ly - 14'(top));
			pw_s1   <= {13'b0, mosaic_level_q} * {7'b0, ext_w};
			ph_s1   <= {13'b0, mosaic_level_q} * {7'b0, ext_h};

			item_s2 <= item_s1;
			dcol_s2 <= dcol_s1;
			drow_s2 <= drow_s1;
			szw_s2  <= blk_size(pw_s1);
			szh_s2  <= blk_size(ph_s1);

			item_s3 <= item_s2;
			dcol_s3 <= dcol_s2;
			drow_s3 <= drow_s2;
			bw_s3   <= item_s2.origin ? szw_s2 : blk_w_q;
			bh_s3   <= item_s2.origin ? szh_s2 : blk_h_q;

			item_mod_s[0] <= item_s3;
			for (int i = 1; i < MOD_STAGES; i++) begin
				item_mod_s[i] <= item_mod_s[i-1];
			end
		end
	end

	// Front pipeline valids and block size latch at the frame origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			blk_w_q <= BLK_W'(2);
			blk_h_q <= BLK_W'(2);
			for (int i = 0; i < MOD_STAGES; i++) begin
				v_mod_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1       <= src_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_mod_s[0] <= v_s3;
			for (int i = 1; i < MOD_STAGES; i++) begin
				v_mod_s[i] <= v_mod_s[i-1];
			end
			if (v_s2 && item_s2.origin) begin
				blk_w_q <= szw_s2;
				blk_h_q <= szh_s2;
			end
		end
	end

	// Block phases
	nrm_modpipe u_mod_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.dividend  (dcol_s3),
		.divisor   (bw_s3),
		.remainder (rem_col)
	);

	nrm_modpipe u_mod_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.dividend  (drow_s3),
		.divisor   (bh_s3),
		.remainder (rem_row)
	);

	// Build the writeback request
	always_comb begin
		wb_req.px        = item_mod_s[MOD_STAGES-1].px;
		wb_req.slot      = item_mod_s[MOD_STAGES-1].slot;
		wb_req.is_luma   = item_mod_s[MOD_STAGES-1].is_luma;
		wb_req.in_rect   = item_mod_s[MOD_STAGES-1].in_rect;
		wb_req.frame_end = item_mod_s[MOD_STAGES-1].frame_end;
		wb_req.rph_zero  = rem_row == '0;
		wb_req.cph_zero  = rem_col == '0;
		wb_req.cph_one   = rem_col == DVD_W'(1);
		wb_req.cph_odd   = rem_col[0];
	end

	nrm_line_wb u_line_wb (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (v_mod_s[MOD_STAGES-1]),
		.req       (wb_req),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			dst_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_data_q <= res;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	// Latched block sizes stay even and at least two
	a_blk_even: assert property (@(posedge clk) disable iff (!arst_n)
		!blk_w_q[0] && !blk_h_q[0] && (blk_w_q >= BLK_W'(2)) && (blk_h_q >= BLK_W'(2)))
		else $error("block size odd or below two");

	// An origin byte leaving stage two loads its computed sizes
	a_blk_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 && item_s2.origin |=> (blk_w_q == $past(szw_s2))
			&& (blk_h_q == $past(szh_s2)))
		else $error("block size not latched at frame origin");

	// Row position never runs past the tallest frame
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		14'(row_q) < 14'(MAX_HEIGHT + MAX_HEIGHT / 2))
		else $error("row position out of range");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the NV21 region mosaic core
// Streams NV21 bytes through the core with random gaps on both handshakes
// and random region settings. A bench-side copy of the mosaic arithmetic
// predicts every output byte and its frame-end flag, which are compared in
// order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrm_pkg::*;

	localparam int RUN_LIMIT  = 5_000_000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_ready;
	in_t                   src_data  = '0;
	logic                  dst_valid;
	logic                  dst_ready = 1'b0;
	out_t                  dst_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	nv21_region_mosaic_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Region settings as the core holds them
	logic [12:0] set_width  = 13'd1920;
	logic [12:0] set_height = 13'd1080;
	logic [11:0] set_left   = '0;
	logic [11:0] set_top    = '0;
	logic [12:0] set_right  = '0;
	logic [12:0] set_bottom = '0;
	logic [6:0]  set_level  = 7'd10;

	// Mosaic state mirrored on the bench side
	logic [7:0]  line_copy [MAX_WIDTH];
	bit          line_copy_valid [MAX_WIDTH];
	logic [7:0]  luma_hold = '0;
	logic [15:0] vu_hold   = '0;
	int unsigned at_col    = 0;
	int unsigned at_row    = 0;
	int unsigned blk_cols  = 2;
	int unsigned blk_rows  = 2;

	out_t pending_bytes [$];
	int   mismatch_count = 0;
	int   cycle_count    = 0;
	bit   calm           = 1'b0;
	int   sink_wait      = 0;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	// Block size: level percent of the extent, even, never below 2
	function automatic int unsigned blk_span(input int unsigned lo, input int unsigned hi);
		int unsigned ext;
		int unsigned s;
		ext = (hi > lo) ? hi - lo : 0;
		s = (int'(set_level) * ext) / 100;
		s = s & ~32'd1;
		return (s < 2) ? 2 : s;
	endfunction

	// Position of the next byte, its luma row and whether the region covers it
	function automatic void locate(input bit start, output int unsigned c,
			output int unsigned r, output int unsigned ly, output bit covered);
		int unsigned h;
		int unsigned left;
		int unsigned top;
		h = clamp_dim(set_height, MAX_HEIGHT);
		left = set_left & ~12'd1;
		top = set_top & ~12'd1;
		c = start ? 0 : at_col;
		r = start ? 0 : at_row;
		ly = (r < h) ? r : 2 * (r - h);
		covered = ly >= top && ly < set_bottom && c >= left && c < set_right;
	endfunction

	// True when the next byte, sent without a frame start, reads an empty slot
	function automatic bit hits_unwritten();
		int unsigned c;
		int unsigned r;
		int unsigned ly;
		bit          covered;
		locate(1'b0, c, r, ly, covered);
		if (!covered || (c == 0 && r == 0)) return 1'b0;
		return ((ly - (set_top & ~12'd1)) % blk_rows) != 0 && !line_copy_valid[c % MAX_WIDTH];
	endfunction

	// Work out one output byte and advance the mirrored state
	function automatic out_t mosaic_predict(input in_t req);
		int unsigned w;
		int unsigned h;
		int unsigned rows_total;
		int unsigned c;
		int unsigned r;
		int unsigned ly;
		int unsigned slot;
		int unsigned rph;
		int unsigned cph;
		bit          covered;
		logic [7:0]  res;
		out_t        o;
		w = clamp_dim(set_width, MAX_WIDTH);
		h = clamp_dim(set_height, MAX_HEIGHT);
		rows_total = h + h / 2;
		locate(req.frame_start, c, r, ly, covered);
		slot = c % MAX_WIDTH;
		res = req.pixel_in;

		// latch block size at the frame origin
		if (c == 0 && r == 0) begin
			blk_cols = blk_span(set_left & ~12'd1, set_right);
			blk_rows = blk_span(set_top & ~12'd1, set_bottom);
		end

		if (covered) begin
			rph = (ly - (set_top & ~12'd1)) % blk_rows;
			cph = (c - (set_left & ~12'd1)) % blk_cols;
			if (rph != 0) begin
				res = line_copy[slot];
			end else if (r < h) begin
				if (cph == 0) luma_hold = req.pixel_in;
				else res = luma_hold;
			end else if (cph == 0) begin
				vu_hold[7:0] = req.pixel_in;
			end else if (cph == 1) begin
				vu_hold[15:8] = req.pixel_in;
			end else begin
				res = (cph % 2 == 1) ? vu_hold[15:8] : vu_hold[7:0];
			end
		end
		line_copy[slot] = res;
		line_copy_valid[slot] = 1'b1;

		o.pixel_out = res;
		o.frame_end = (r == rows_total - 1) && (c == w - 1);

		// advance position, wrapping at row and frame end
		if (c + 1 >= w) begin
			at_col = 0;
			at_row = (r + 1 >= rows_total) ? 0 : r + 1;
		end else begin
			at_col = c + 1;
			at_row = r;
		end
		return o;
	endfunction

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Hold off the result side at random
	always @(posedge clk) begin
		if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= 1'b1;
			sink_wait <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// Compare each output byte with the oldest prediction
	always @(posedge clk) begin : check_bytes
		out_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected byte, expected none, got %h end %b",
					$time, dst_data.pixel_out, dst_data.frame_end);
			end else begin
				want = pending_bytes.pop_front();
				if (dst_data.pixel_out !== want.pixel_out) begin
					mismatch_count++;
					$display("%0t: pixel_out expected %h got %h",
						$time, want.pixel_out, dst_data.pixel_out);
				end
				if (dst_data.frame_end !== want.frame_end) begin
					mismatch_count++;
					$display("%0t: frame_end expected %b got %b",
						$time, want.frame_end, dst_data.frame_end);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Send one request and wait for it to be taken
	task automatic send_byte(input logic [7:0] px, input bit start);
		in_t req;
		int  gap;
		gap = pick_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// restart the frame rather than read a line-store slot never filled
		if (!start && hits_unwritten()) start = 1'b1;
		req.pixel_in = px;
		req.frame_start = start;
		pending_bytes.push_back(mosaic_predict(req));
		src_valid <= 1'b1;
		src_data <= req;
		do @(posedge clk); while (!src_ready);
	endtask

	// Random bytes; frame start mostly at the frame origin, rarely elsewhere
	task automatic send_stream(input int count, input int noise_pm, input bit open_frame);
		bit st;
		for (int i = 0; i < count; i++) begin
			if (i == 0) st = open_frame || ($urandom_range(0, 1) == 1);
			else if (at_col == 0 && at_row == 0) st = ($urandom_range(0, 4) != 0);
			else st = ($urandom_range(0, 999) < noise_pm);
			send_byte(8'($urandom_range(0, 255)), st);
		end
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  set_width = data;
			CFG_FRAME_HEIGHT: set_height = data;
			CFG_RECT_LEFT:    set_left = data[11:0];
			CFG_RECT_TOP:     set_top = data[11:0];
			CFG_RECT_RIGHT:   set_right = data;
			CFG_RECT_BOTTOM:  set_bottom = data;
			CFG_MOSAIC_LEVEL: set_level = data[6:0];
			default: ;
		endcase
	endtask

	// Rewrite every register once the core has gone quiet
	task automatic program_mosaic(input logic [12:0] w, input logic [12:0] h,
			input logic [12:0] l, input logic [12:0] t, input logic [12:0] r,
			input logic [12:0] b, input logic [12:0] lvl);
		wait_drained();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_RECT_LEFT, l);
		write_reg(CFG_RECT_TOP, t);
		write_reg(CFG_RECT_RIGHT, r);
		write_reg(CFG_RECT_BOTTOM, b);
		write_reg(CFG_MOSAIC_LEVEL, lvl);
		cfg_we <= 1'b0;
	endtask

	// Reset settings: empty region, every byte passes through
	task automatic test_reset_defaults();
		calm = 1'b1;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Tiny frame, odd corner, whole frame in one block, then wrap and restart
	task automatic test_tiny_frame();
		logic [7:0] bytes [15] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F,
			8'hFE, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h11, 8'h22, 8'h44};
		program_mosaic(13'd4, 13'd2, 13'd1, 13'd1, 13'd4, 13'd2, 13'd100);
		calm = 1'b0;
		for (int i = 0; i < 15; i++) send_byte(bytes[i], i == 0 || i == 14);
	endtask

	// Register extremes: widest, tallest, region outside the frame
	task automatic test_geometry_extremes();
		calm = 1'b0;
		program_mosaic(13'd8191, 13'd0, 13'd0, 13'd0, 13'd8191, 13'd8191, 13'd1);
		send_stream(300, 0, 1'b1);
		calm = 1'b1;
		program_mosaic(13'd1, 13'd4096, 13'd1, 13'd1, 13'd2, 13'd4096, 13'd3);
		send_stream(300, 0, 1'b1);
		calm = 1'b0;
		program_mosaic(13'd16, 13'd8, 13'd4095, 13'd4095, 13'd0, 13'd0, 13'd0);
		send_stream(40, 0, 1'b1);
	endtask

	// Random regions over mostly small frames, some phases ending mid-frame
	task automatic test_random_regions(input int budget);
		int unsigned w;
		int unsigned h;
		int unsigned we;
		int unsigned he;
		int unsigned l;
		int unsigned t;
		int unsigned r;
		int unsigned b;
		int unsigned lvl;
		int          n;
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 1);
				1: w = $urandom_range(4097, 8191);
				2: w = $urandom_range(25, 200);
				default: w = $urandom_range(2, 24);
			endcase
			case ($urandom_range(0, 9))
				0: h = $urandom_range(0, 1);
				1: h = $urandom_range(4097, 8191);
				2: h = $urandom_range(13, 60);
				default: h = $urandom_range(2, 12);
			endcase
			we = clamp_dim(w, MAX_WIDTH);
			he = clamp_dim(h, MAX_HEIGHT);
			l = $urandom_range(0, we + 2);
			t = $urandom_range(0, he + 2);
			r = $urandom_range(0, we + 4);
			b = $urandom_range(0, he + 4);
			if ($urandom_range(0, 7) == 0) begin
				l = 0;
				t = 0;
				r = we;
				b = he;
			end
			if ($urandom_range(0, 15) == 0) l = l | 13'h1000;
			if ($urandom_range(0, 15) == 0) t = t | 13'h1000;
			case ($urandom_range(0, 5))
				0: lvl = $urandom_range(0, 8191);
				1: lvl = 100;
				default: lvl = $urandom_range(25, 100);
			endcase
			program_mosaic(13'(w), 13'(h), 13'(l), 13'(t), 13'(r), 13'(b), 13'(lvl));
			calm = ($urandom_range(0, 4) == 0);
			n = $urandom_range(100, 250);
			send_stream(n, 4, 1'b0);
			budget -= n;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_tiny_frame();
		test_geometry_extremes();
		test_random_regions(1300);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
